FILE: sv/ordered_dither_gray_scaler_unit_assert.svh
// ----------------------------------------------------------------------------
// ordered dither gray scaler assertion macros
// shared property forms for the clocked checks, using clk and rst in scope
// ----------------------------------------------------------------------------
`ifndef ORDERED_DITHER_GRAY_SCALER_UNIT_ASSERT_SVH
`define ORDERED_DITHER_GRAY_SCALER_UNIT_ASSERT_SVH

// same-cycle implication
`define ODGS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ODGS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/odgs_pkg.sv
// ----------------------------------------------------------------------------
// odgs_pkg
// shared types, constants and the dither function of the gray scaler
// ----------------------------------------------------------------------------
`default_nettype none

package odgs_pkg;

  localparam int DEFAULT_SOURCE_WIDTH  = 280;
  localparam int DEFAULT_SOURCE_HEIGHT = 192;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_ROWS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_STRIDE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LEFT   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_TOP    = 3'd6;

  // reset values
  localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd560;
  localparam logic [11:0] RST_SCREEN_ROWS   = 12'd384;
  localparam logic [11:0] RST_ROW_STRIDE    = 12'd560;
  localparam logic [11:0] RST_TARGET_WIDTH  = 12'd560;
  localparam logic [10:0] RST_TARGET_HEIGHT = 11'd384;
  localparam logic [11:0] RST_TARGET_LEFT   = 12'd0;
  localparam logic [11:0] RST_TARGET_TOP    = 12'd0;

  localparam logic [15:0] LUMA_R     = 16'd54;
  localparam logic [15:0] LUMA_G     = 16'd183;
  localparam logic [15:0] LUMA_B     = 16'd19;
  localparam logic [8:0]  DITHER_BIAS = 9'd32;   // 128 / 4
  localparam logic [7:0]  GRAY_MAX   = 8'd255;
  localparam logic [7:0]  GRAY_MASK  = 8'hF0;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_rows;
    logic [11:0] row_stride;
    logic [11:0] target_width;
    logic [10:0] target_height;
    logic [11:0] target_left;
    logic [11:0] target_top;
  } cfg_t;

  // one clipped screen rectangle, end bounds exclusive
  typedef struct packed {
    logic [11:0] y0;
    logic [11:0] y1;
    logic [11:0] x0;
    logic [11:0] x1;
    logic [7:0]  gray;
  } span_t;

  // bayer threshold divided by four, index {row[1:0], col[1:0]}
  function automatic logic [5:0] bayer_quarter(input logic [3:0] idx);
    logic [5:0] val;
    case (idx)
      4'd0:  val = 6'd0;
      4'd1:  val = 6'd32;
      4'd2:  val = 6'd8;
      4'd3:  val = 6'd40;
      4'd4:  val = 6'd48;
      4'd5:  val = 6'd16;
      4'd6:  val = 6'd56;
      4'd7:  val = 6'd24;
      4'd8:  val = 6'd12;
      4'd9:  val = 6'd44;
      4'd10: val = 6'd4;
      4'd11: val = 6'd36;
      4'd12: val = 6'd60;
      4'd13: val = 6'd28;
      4'd14: val = 6'd52;
      4'd15: val = 6'd20;
      default: val = 6'd0;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] dither_gray(input logic [23:0] color,
                                             input logic [1:0]  row,
                                             input logic [1:0]  col);
    logic [15:0] wsum;
    logic [8:0]  biased;
    logic [8:0]  shifted;
    logic [7:0]  gray;
    wsum   = LUMA_R * 16'(color[7:0]) + LUMA_G * 16'(color[15:8])
           + LUMA_B * 16'(color[23:16]);
    biased = 9'(wsum[15:8]) + 9'(bayer_quarter({row, col}));
    shifted = biased - DITHER_BIAS;
    if (biased < DITHER_BIAS) begin
      gray = 8'd0;
    end else if (shifted[8]) begin
      gray = GRAY_MAX;
    end else begin
      gray = shifted[7:0];
    end
    return gray & GRAY_MASK;
  endfunction

endpackage

`default_nettype wire

FILE: sv/odgs_div.sv
// ----------------------------------------------------------------------------
// odgs_div
// division by a fixed divisor through a reciprocal multiply, result registered
// ----------------------------------------------------------------------------
`default_nettype none

module odgs_div #(
  parameter int DIVISOR = 280,
  parameter int NW      = 20,
  parameter int QW      = 12
) (
  input  wire logic          clk,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  output logic [QW-1:0]      quotient
);

  // exact for every dividend below 2**NW, the reciprocal error stays
  // under 2**(SH-NW)
  localparam int SH = NW + $clog2(DIVISOR);
  localparam int MW = NW + 1;
  localparam int PW = NW + MW;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - 1)
                             / longint'(DIVISOR);

  logic [PW-1:0] prod;

  assign prod = PW'(dividend) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= QW'(prod >> SH);
    end
  end

endmodule

`default_nettype wire

FILE: sv/odgs_front.sv
// ----------------------------------------------------------------------------
// odgs_front
// takes source pixels, dithers them and works out the clipped screen span
// ----------------------------------------------------------------------------
`default_nettype none

module odgs_front
  import odgs_pkg::*;
#(
  parameter int SOURCE_WIDTH  = DEFAULT_SOURCE_WIDTH,
  parameter int SOURCE_HEIGHT = DEFAULT_SOURCE_HEIGHT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire logic [23:0] pixel_color,
  output logic       push_valid,
  output span_t      push_span,
  input  wire logic  queue_full
);

  localparam int QWX = $clog2(8 * SOURCE_WIDTH + 1);
  localparam int QWY = $clog2(8 * SOURCE_HEIGHT + 1);
  localparam int NXW = $clog2(SOURCE_WIDTH * 8 * SOURCE_WIDTH + 1);
  localparam int NYW = $clog2(SOURCE_HEIGHT * 8 * SOURCE_HEIGHT + 1);
  localparam int CW  = $clog2(SOURCE_WIDTH);
  localparam int RW  = $clog2(SOURCE_HEIGHT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]     state;
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [QWX-1:0] tw;
  logic [QWY-1:0] th;
  logic [NXW-1:0] nx0, nx1;
  logic [NYW-1:0] ny0, ny1;
  logic [QWX-1:0] qx0, qx1;
  logic [QWY-1:0] qy0, qy1;
  logic [7:0]     gray;
  logic [12:0]    x0, x1, y0, y1, x1c, y1c;
  logic           nonempty;
  span_t          span;
  logic           accept;

  assign accept = s_tvalid && s_tready;
  assign s_tready = state == ST_IDLE;

  // oversized targets saturate at eight times the source size
  assign tw = (cfg.target_width > 12'(8 * SOURCE_WIDTH))
              ? QWX'(8 * SOURCE_WIDTH) : QWX'(cfg.target_width);
  assign th = (cfg.target_height > 11'(8 * SOURCE_HEIGHT))
              ? QWY'(8 * SOURCE_HEIGHT) : QWY'(cfg.target_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_START;
            if (col == CW'(SOURCE_WIDTH - 1)) begin
              col <= '0;
              row <= (row == RW'(SOURCE_HEIGHT - 1)) ? '0 : row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        ST_START: state <= ST_DIV;
        ST_DIV:   state <= ST_PUSH;
        ST_PUSH: begin
          if (!nonempty || !queue_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gray <= dither_gray(pixel_color, row[1:0], col[1:0]);
      nx0  <= NXW'(col) * NXW'(tw);
      nx1  <= (NXW'(col) + 1'b1) * NXW'(tw);
      ny0  <= NYW'(row) * NYW'(th);
      ny1  <= (NYW'(row) + 1'b1) * NYW'(th);
    end
  end

  odgs_div #(.DIVISOR(SOURCE_WIDTH), .NW(NXW), .QW(QWX)) u_div_x0 (
    .clk, .start(state == ST_START), .dividend(nx0), .quotient(qx0));
  odgs_div #(.DIVISOR(SOURCE_WIDTH), .NW(NXW), .QW(QWX)) u_div_x1 (
    .clk, .start(state == ST_START), .dividend(nx1), .quotient(qx1));
  odgs_div #(.DIVISOR(SOURCE_HEIGHT), .NW(NYW), .QW(QWY)) u_div_y0 (
    .clk, .start(state == ST_START), .dividend(ny0), .quotient(qy0));
  odgs_div #(.DIVISOR(SOURCE_HEIGHT), .NW(NYW), .QW(QWY)) u_div_y1 (
    .clk, .start(state == ST_START), .dividend(ny1), .quotient(qy1));

  // offsets and clipping at the screen edge
  always_comb begin
    x0  = 13'(cfg.target_left) + 13'(qx0);
    x1  = 13'(cfg.target_left) + 13'(qx1);
    y0  = 13'(cfg.target_top) + 13'(qy0);
    y1  = 13'(cfg.target_top) + 13'(qy1);
    x1c = (x1 < 13'(cfg.screen_width)) ? x1 : 13'(cfg.screen_width);
    y1c = (y1 < 13'(cfg.screen_rows)) ? y1 : 13'(cfg.screen_rows);
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      nonempty  <= (x0 < x1c) && (y0 < y1c);
      span.x0   <= x0[11:0];
      span.x1   <= x1c[11:0];
      span.y0   <= y0[11:0];
      span.y1   <= y1c[11:0];
      span.gray <= gray;
    end
  end

  assign push_valid = (state == ST_PUSH) && nonempty;
  assign push_span  = span;

endmodule

`default_nettype wire

FILE: sv/odgs_queue.sv
// ----------------------------------------------------------------------------
// odgs_queue
// short first-in first-out queue of spans between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module odgs_queue
  import odgs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  input  wire span_t push_span,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output span_t      head_span
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  span_t       slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          take;

  assign full       = count == (PW+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign push       = push_valid && !full;
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_span;
    end
  end

  assign head_span = slots[rd_ptr];

endmodule

`default_nettype wire

FILE: sv/odgs_back.sv
// ----------------------------------------------------------------------------
// odgs_back
// walks each span row by row and issues one framebuffer write per cycle while m_tready allows
// ----------------------------------------------------------------------------
`default_nettype none

module odgs_back
  import odgs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [11:0] row_stride,
  input  wire logic        head_valid,
  input  wire span_t       head_span,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      write_address,
  output logic [7:0]       gray_value,
  output logic             last_write
);

`include "ordered_dither_gray_scaler_unit_assert.svh"

  logic        busy;
  span_t       cur;
  logic [11:0] x, y;
  logic [11:0] x_inc, y_inc;
  logic [23:0] base;
  logic        slot_free;
  logic        emit;
  logic        row_end;
  logic        is_last;
  logic        fire_last;

  assign x_inc     = x + 1'b1;
  assign y_inc     = y + 1'b1;
  assign row_end   = x_inc == cur.x1;
  assign is_last   = row_end && (y_inc == cur.y1);
  assign slot_free = !m_tvalid || m_tready;
  assign emit      = busy && slot_free;
  assign fire_last = emit && is_last;
  assign pop       = head_valid && (!busy || fire_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (fire_last) begin
        busy <= 1'b0;
      end
      if (slot_free) begin
        m_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      write_address <= base + 24'(x);
      gray_value    <= cur.gray;
      last_write    <= is_last;
    end
    if (pop) begin
      cur  <= head_span;
      x    <= head_span.x0;
      y    <= head_span.y0;
      base <= 24'(head_span.y0) * 24'(row_stride);
    end else if (emit) begin
      if (row_end) begin
        x    <= cur.x0;
        y    <= y_inc;
        base <= base + 24'(row_stride);
      end else begin
        x <= x_inc;
      end
    end
  end

  `ODGS_ASSERT_IMP(a_walk_inside_span, busy, (x < cur.x1) && (y < cur.y1), "walk left its span")
  `ODGS_ASSERT_NXT(a_idle_after_last, fire_last && !pop, !busy, "still busy after last write")
  `ODGS_ASSERT_IMP(a_gray_low_clear, m_tvalid, gray_value[3:0] == 4'd0, "gray low bits set")

endmodule

`default_nettype wire

FILE: sv/ordered_dither_gray_scaler_unit.sv
// ----------------------------------------------------------------------------
// ordered_dither_gray_scaler_unit
// 4x4 ordered dither of rgb source pixels with nearest-neighbour upscaling
// into clipped framebuffer byte writes
// ----------------------------------------------------------------------------
//  channel  dir  width  beat content
//  cfg      in   3+12   register index, write data (write on cfg_we)
//  s_axis   in   24     one source pixel in raster order
//  m_axis   out  32+1   one framebuffer byte write, tlast on a pixel's final
//
//  front: each pixel goes through accept, reciprocal divide, clip and queue push,
//  with no new pixel taken before its push; a push waits while the span queue is full
//  back: one write per cycle while m_tready allows, working beside the front
//  a pixel with an empty span causes no beat, its counters still advance
//  reset: config to its defaults, source row and column to zero, no sweep
//  a stalled m_axis fills the span queue and then holds s_tready low
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_dither_gray_scaler_unit
  import odgs_pkg::*;
#(
  parameter int SOURCE_WIDTH  = DEFAULT_SOURCE_WIDTH,
  parameter int SOURCE_HEIGHT = DEFAULT_SOURCE_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [23:0]            s_tdata,   // pixel_color[23:0]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [31:0]                 m_tdata,   // write_address[23:0], gray_value[31:24]
  output logic                        m_tlast    // last_write
);

  cfg_t        cfg;
  logic        push_valid;
  span_t       push_span;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  span_t       head_span;
  logic [23:0] write_address;
  logic [7:0]  gray_value;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RST_SCREEN_WIDTH;
      cfg.screen_rows   <= RST_SCREEN_ROWS;
      cfg.row_stride    <= RST_ROW_STRIDE;
      cfg.target_width  <= RST_TARGET_WIDTH;
      cfg.target_height <= RST_TARGET_HEIGHT;
      cfg.target_left   <= RST_TARGET_LEFT;
      cfg.target_top    <= RST_TARGET_TOP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        CFG_SCREEN_ROWS:   cfg.screen_rows   <= cfg_data;
        CFG_ROW_STRIDE:    cfg.row_stride    <= cfg_data;
        CFG_TARGET_WIDTH:  cfg.target_width  <= cfg_data;
        CFG_TARGET_HEIGHT: cfg.target_height <= cfg_data[10:0];
        CFG_TARGET_LEFT:   cfg.target_left   <= cfg_data;
        CFG_TARGET_TOP:    cfg.target_top    <= cfg_data;
        default: ;  // unused index, ignored
      endcase
    end
  end

  // front: accept, dither, span arithmetic and clipping
  odgs_front #(
    .SOURCE_WIDTH (SOURCE_WIDTH),
    .SOURCE_HEIGHT(SOURCE_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .pixel_color(s_tdata),
    .push_valid (push_valid),
    .push_span  (push_span),
    .queue_full (queue_full)
  );

  // span queue parting the two halves
  odgs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_span (push_span),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_span (head_span)
  );

  // back: rectangle walk and registered output beat
  odgs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .row_stride   (cfg.row_stride),
    .head_valid   (head_valid),
    .head_span    (head_span),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .write_address(write_address),
    .gray_value   (gray_value),
    .last_write   (m_tlast)
  );

  assign m_tdata = {gray_value, write_address};

endmodule

`default_nettype wire

FILE: dv/tb_ordered_dither_gray_scaler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_dither_gray_scaler_unit
// self-checking bench for the ordered dither gray scaler: source pixels go in
// on s_axis, a local model of the dither and span expansion predicts every
// framebuffer write, and each m_axis beat is checked against the oldest
// prediction; covers register extremes, clipping and random settings, with
// enough pixels that the column counter wraps into the next source row
// ----------------------------------------------------------------------------

module tb_ordered_dither_gray_scaler_unit;
  import odgs_pkg::*;

  localparam int unsigned SRC_W           = DEFAULT_SOURCE_WIDTH;
  localparam int unsigned SRC_H           = DEFAULT_SOURCE_HEIGHT;
  localparam int unsigned MAX_WRITES      = 64;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 56;
  localparam int unsigned CYCLE_LIMIT     = 5_000_000;

  // one predicted framebuffer write
  typedef struct packed {
    logic [23:0] addr;
    logic [7:0]  gray;
    logic        last;
  } fb_write_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [23:0]            s_tdata   = '0;   // pixel_color[23:0]
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [31:0]            m_tdata;          // write_address[23:0], gray_value[31:24]
  logic                   m_tlast;          // last_write

  // local copy of the block's settings and raster position
  cfg_t        model_cfg;
  logic [7:0]  src_row;
  logic [8:0]  src_col;

  fb_write_t   pending_writes[$];
  int unsigned mismatches  = 0;
  int unsigned writes_seen = 0;

  // idle limits for the current phase, zero gives back-to-back beats
  int unsigned src_gap_max   = 0;
  int unsigned snk_stall_max = 0;

  ordered_dither_gray_scaler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // full 4x4 bayer threshold, 0..240
  function automatic int bayer_threshold(input logic [1:0] r, input logic [1:0] c);
    case ({r, c})
      4'd0:  return 0;
      4'd1:  return 128;
      4'd2:  return 32;
      4'd3:  return 160;
      4'd4:  return 192;
      4'd5:  return 64;
      4'd6:  return 224;
      4'd7:  return 96;
      4'd8:  return 48;
      4'd9:  return 176;
      4'd10: return 16;
      4'd11: return 144;
      4'd12: return 240;
      4'd13: return 112;
      4'd14: return 208;
      default: return 80;
    endcase
  endfunction

  function automatic logic [7:0] dithered_level(input logic [23:0] color,
                                                input logic [1:0]  r,
                                                input logic [1:0]  c);
    int unsigned luma;
    int          level;
    luma  = (32'd54 * color[7:0] + 32'd183 * color[15:8] + 32'd19 * color[23:16]) >> 8;
    // signed division truncates toward zero
    level = int'(luma) + (bayer_threshold(r, c) - 128) / 4;
    if (level < 0)   level = 0;
    if (level > 255) level = 255;
    return 8'(level) & 8'hF0;
  endfunction

  // expected writes of one accepted pixel, then step the raster position
  task automatic expand_pixel(input logic [23:0] color);
    fb_write_t   w;
    logic [7:0]  gray;
    int unsigned tw, th, y0, y1, x0, x1, rows, cols, total, k;
    gray = dithered_level(color, src_row[1:0], src_col[1:0]);
    tw = model_cfg.target_width;
    th = model_cfg.target_height;
    if (tw > 8 * SRC_W) tw = 8 * SRC_W;
    if (th > 8 * SRC_H) th = 8 * SRC_H;
    y0 = model_cfg.target_top  + src_row * th / SRC_H;
    y1 = model_cfg.target_top  + (src_row + 1) * th / SRC_H;
    x0 = model_cfg.target_left + src_col * tw / SRC_W;
    x1 = model_cfg.target_left + (src_col + 1) * tw / SRC_W;
    // clip at the right and bottom screen edges
    if (y1 > model_cfg.screen_rows)  y1 = model_cfg.screen_rows;
    if (x1 > model_cfg.screen_width) x1 = model_cfg.screen_width;
    rows  = (y1 > y0) ? y1 - y0 : 0;
    cols  = (x1 > x0) ? x1 - x0 : 0;
    total = rows * cols;
    if (total > MAX_WRITES) total = MAX_WRITES;
    k = 0;
    for (int unsigned y = y0; y < y1 && k < total; y++) begin
      for (int unsigned x = x0; x < x1 && k < total; x++) begin
        w.addr = 24'(y * model_cfg.row_stride + x);
        w.gray = gray;
        w.last = (k == total - 1);
        pending_writes.push_back(w);
        k++;
      end
    end
    // raster counters move on whether or not anything was written
    if (src_col == SRC_W - 1) begin
      src_col = '0;
      src_row = (src_row == SRC_H - 1) ? 8'd0 : src_row + 8'd1;
    end else begin
      src_col = src_col + 9'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic check_write(input logic [31:0] data, input logic last);
    fb_write_t want;
    if (pending_writes.size() == 0) begin
      flag_error($sformatf("write beat %0d with nothing expected: addr %06h gray %02h last %0b",
                           writes_seen, data[23:0], data[31:24], last));
    end else begin
      want = pending_writes.pop_front();
      if (data[23:0] !== want.addr || data[31:24] !== want.gray || last !== want.last)
        flag_error($sformatf({"write beat %0d: addr exp %06h got %06h, gray exp %02h got %02h,",
                              " last exp %0b got %0b"},
                             writes_seen, want.addr, data[23:0], want.gray, data[31:24],
                             want.last, last));
    end
    writes_seen++;
  endtask

  // framebuffer write side: random stall before every beat
  initial begin : write_sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, snk_stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      check_write(m_tdata, m_tlast);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ERROR: cycle limit reached, %0d writes still expected", pending_writes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one source pixel beat; valid stays high into the next beat when no gap is drawn
  task automatic send_pixel(input logic [23:0] color);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= color;
    do @(posedge clk); while (s_tready !== 1'b1);
    expand_pixel(color);
  endtask

  // sender goes quiet until every predicted write has come out
  task automatic hold_until_written();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  // an empty-span pixel may still be in the front end after the last write
  task automatic drain_writes();
    hold_until_written();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // all seven registers, written only once the block has gone idle
  task automatic load_settings(input cfg_t c);
    drain_writes();
    put_reg(CFG_SCREEN_WIDTH,  c.screen_width);
    put_reg(CFG_SCREEN_ROWS,   c.screen_rows);
    put_reg(CFG_ROW_STRIDE,    c.row_stride);
    put_reg(CFG_TARGET_WIDTH,  c.target_width);
    put_reg(CFG_TARGET_HEIGHT, CFG_DATA_W'(c.target_height));
    put_reg(CFG_TARGET_LEFT,   c.target_left);
    put_reg(CFG_TARGET_TOP,    c.target_top);
    cfg_we    <= 1'b0;
    model_cfg  = c;
  endtask

  function automatic cfg_t make_cfg(input logic [11:0] sw, input logic [11:0] sh,
                                    input logic [11:0] stride, input logic [11:0] tw,
                                    input logic [10:0] th, input logic [11:0] left,
                                    input logic [11:0] top);
    cfg_t c;
    c.screen_width  = sw;
    c.screen_rows   = sh;
    c.row_stride    = stride;
    c.target_width  = tw;
    c.target_height = th;
    c.target_left   = left;
    c.target_top    = top;
    return c;
  endfunction

  function automatic logic [23:0] pick_color();
    logic [23:0] c;
    c = 24'($urandom);
    // fully saturated channels drive the dither sum into both clamps
    if ($urandom_range(0, 3) == 0) c = {{8{c[16]}}, {8{c[8]}}, {8{c[0]}}};
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings give 2x2 writes per pixel; first columns walk the dither row
  task automatic test_default_settings();
    src_gap_max   = 0;
    snk_stall_max = 0;
    send_pixel(24'h000000);   // black on a negative threshold clamps at zero
    send_pixel(24'hFFFFFF);
    send_pixel(24'h0000FF);   // pure red
    send_pixel(24'hFFFFFF);   // white on a positive threshold clamps at full scale
    send_pixel(24'h00FF00);   // pure green
    send_pixel(24'hFF0000);   // pure blue
    send_pixel(24'h555555);
    send_pixel(24'hAAAAAA);
    send_pixel(24'h808080);
    send_pixel(24'h7F7F7F);
  endtask

  task automatic test_range_extremes();
    src_gap_max   = 12;
    snk_stall_max = 12;
    // oversized target saturates, eight by eight writes per pixel
    load_settings(make_cfg(12'd4095, 12'd4095, 12'd4095, 12'd4095, 11'd2047, 12'd0, 12'd0));
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    // largest addresses: bottom right of the biggest screen, first pixel cut by the
    // right edge, the next one falls off it entirely
    load_settings(make_cfg(12'd4095, 12'd4095, 12'd4095, 12'd2240, 11'd1536,
                           12'(4088 - 8 * src_col), 12'(4086 - 8 * src_row)));
    send_pixel(24'h123456);
    send_pixel(24'hFEDCBA);
    // zero target width and a one pixel screen both leave nothing to write
    load_settings(make_cfg(12'd560, 12'd384, 12'd560, 12'd0, 11'd0, 12'd0, 12'd0));
    send_pixel(24'hFFFFFF);
    load_settings(make_cfg(12'd1, 12'd1, 12'd1, 12'd560, 11'd384, 12'd0, 12'd0));
    send_pixel(24'h00FF00);
    // back to the reset values; position must have moved on over the empty pixels
    load_settings(make_cfg(RST_SCREEN_WIDTH, RST_SCREEN_ROWS, RST_ROW_STRIDE,
                           RST_TARGET_WIDTH, RST_TARGET_HEIGHT, RST_TARGET_LEFT,
                           RST_TARGET_TOP));
    send_pixel(24'hC0C0C0);
  endtask

  task automatic test_random_phases();
    cfg_t        c;
    int unsigned reach;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      c.target_width  = ($urandom_range(0, 7) == 0) ? 12'd4095 : 12'($urandom_range(0, 2240));
      c.target_height = ($urandom_range(0, 7) == 0) ? 11'd2047 : 11'($urandom_range(0, 1536));
      c.target_left   = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
      c.target_top    = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
      c.row_stride    = 12'($urandom_range(1, 4095));
      if ($urandom_range(0, 1)) begin
        c.screen_width = 12'd4095;
        c.screen_rows  = 12'd4095;
      end else begin
        // screen edges that cut through the scaled image
        reach = c.target_left + 300;
        if (reach > 4095) reach = 4095;
        c.screen_width = 12'($urandom_range(1, reach));
        reach = c.target_top + 30;
        if (reach > 4095) reach = 4095;
        c.screen_rows = 12'($urandom_range(1, reach));
      end
      load_settings(c);
      // every mix of idle and busy on the two sides
      src_gap_max   = (p % 4 == 0 || p % 4 == 2) ? 12 : 0;
      snk_stall_max = (p % 4 == 0 || p % 4 == 3) ? 12 : 0;
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p % 2 == 1 && i == ITEMS_PER_PHASE / 2) hold_until_written();
        send_pixel(pick_color());
      end
    end
  endtask

  initial begin : main
    model_cfg = make_cfg(RST_SCREEN_WIDTH, RST_SCREEN_ROWS, RST_ROW_STRIDE,
                         RST_TARGET_WIDTH, RST_TARGET_HEIGHT, RST_TARGET_LEFT,
                         RST_TARGET_TOP);
    src_row = '0;
    src_col = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_settings();
    test_range_extremes();
    test_random_phases();
    drain_writes();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/odgs_pkg.sv
sv/odgs_div.sv
sv/odgs_front.sv
sv/odgs_queue.sv
sv/odgs_back.sv
sv/ordered_dither_gray_scaler_unit.sv
dv/tb_ordered_dither_gray_scaler_unit.sv
